// ===== rtl/rrq_pkg.sv =====
// Shared constants and types for the round-robin ready queue.
// No dependencies; imported by the top level.
package rrq_pkg;

  localparam int THREAD_SLOTS = 64;
  localparam int ID_W         = $clog2(THREAD_SLOTS);
  localparam int COUNT_W      = $clog2(THREAD_SLOTS + 1);
  localparam int OP_W         = 2;

  localparam logic [OP_W-1:0] OP_ENQUEUE  = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE   = 2'd1;
  localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd2;

  typedef struct packed {
    logic            we;
    logic [ID_W-1:0] addr;
    logic [ID_W-1:0] data;
  } link_wr_t;

endpackage

// ===== rtl/round_robin_ready_queue_unit.sv =====
// Round-robin ready queue: doubly linked list of thread slots in two link RAMs.
// Depends on rrq_pkg and rrq_ram.
//
// One item is accepted per clock in steady state, unless a result held back by
// out_ready stalls the input. An accepted item reads the forward and backward
// links of its thread, or of the head for a schedule, from the link RAMs on
// the accept edge, is resolved from the stage-one registers in one pass over
// the head, tail, count and queued marks, and its result is registered in the
// output register once that is free. The link RAM read port, with a bypass for
// the write made on the same edge, sets this one-item-per-cycle rate. Queued
// marks are cleared by reset; the link RAMs need no clearing.
module round_robin_ready_queue_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rrq_pkg::OP_W-1:0]     in_operation,
  input  logic [rrq_pkg::ID_W-1:0]     in_thread_id,
  input  logic                         in_current_running,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rrq_pkg::ID_W-1:0]     out_next_thread,
  output logic                         out_next_valid,
  output logic                         out_switch_needed,
  output logic [rrq_pkg::ID_W-1:0]     out_previous_thread,
  output logic                         out_previous_valid,
  output logic [rrq_pkg::COUNT_W-1:0]  out_queue_count
);
  import rrq_pkg::*;

  logic                    s1_valid_r;
  logic [OP_W-1:0]         s1_op_r;
  logic [ID_W-1:0]         s1_tid_r;
  logic                    s1_run_r;

  logic [ID_W-1:0]         head_r, head_nxt;
  logic [ID_W-1:0]         tail_r, tail_nxt;
  logic [COUNT_W-1:0]      count_r, count_nxt;
  logic [THREAD_SLOTS-1:0] mark_r, mark_nxt;
  logic [ID_W-1:0]         run_thr_r, run_thr_nxt;
  logic                    run_valid_r, run_valid_nxt;

  logic                    byp_f_r, byp_b_r;
  logic [ID_W-1:0]         byp_f_data_r, byp_b_data_r;
  logic [ID_W-1:0]         ram_f_q, ram_b_q;
  logic [ID_W-1:0]         rd_f, rd_b;

  link_wr_t                fwd_wr, bwd_wr;
  logic                    push;
  logic [ID_W-1:0]         pick;

  logic [ID_W-1:0]         o_next, o_prev;
  logic                    o_nval, o_sw, o_pval;

  logic                    out_valid_r;
  logic [ID_W-1:0]         out_next_r, out_prev_r;
  logic                    out_nval_r, out_sw_r, out_pval_r;
  logic [COUNT_W-1:0]      out_count_r;

  logic                    res_free, commit, in_fire;
  logic [ID_W-1:0]         head_cur, rd_addr;

  assign res_free = !out_valid_r || out_ready;
  assign commit   = s1_valid_r && res_free;
  assign in_ready = !s1_valid_r || res_free;
  assign in_fire  = in_valid && in_ready;

  assign head_cur = commit ? head_nxt : head_r;
  assign rd_addr  = (in_operation == OP_SCHEDULE) ? head_cur : in_thread_id;

  assign rd_f = byp_f_r ? byp_f_data_r : ram_f_q;
  assign rd_b = byp_b_r ? byp_b_data_r : ram_b_q;

  rrq_ram #(.WIDTH(ID_W), .DEPTH(THREAD_SLOTS)) u_fwd_ram (
    .clk   (clk),
    .we    (commit && fwd_wr.we),
    .waddr (fwd_wr.addr),
    .wdata (fwd_wr.data),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (ram_f_q)
  );

  rrq_ram #(.WIDTH(ID_W), .DEPTH(THREAD_SLOTS)) u_bwd_ram (
    .clk   (clk),
    .we    (commit && bwd_wr.we),
    .waddr (bwd_wr.addr),
    .wdata (bwd_wr.data),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (ram_b_q)
  );

  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    mark_nxt      = mark_r;
    run_thr_nxt   = run_thr_r;
    run_valid_nxt = run_valid_r;
    fwd_wr        = '0;
    bwd_wr        = '0;
    push          = 1'b0;
    pick          = '0;
    o_next        = '0;
    o_nval        = 1'b0;
    o_sw          = 1'b0;
    o_prev        = '0;
    o_pval        = 1'b0;
    case (s1_op_r)
      OP_ENQUEUE: begin
        if (!mark_r[s1_tid_r]) begin
          if (count_r != '0) begin
            fwd_wr = '{we: 1'b1, addr: tail_r, data: s1_tid_r};
            bwd_wr = '{we: 1'b1, addr: s1_tid_r, data: tail_r};
          end else begin
            head_nxt = s1_tid_r;
          end
          tail_nxt           = s1_tid_r;
          mark_nxt[s1_tid_r] = 1'b1;
          count_nxt          = count_r + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (mark_r[s1_tid_r]) begin
          if (s1_tid_r == head_r) begin
            head_nxt = rd_f;
          end else begin
            fwd_wr = '{we: 1'b1, addr: rd_b, data: rd_f};
          end
          if (s1_tid_r == tail_r) begin
            tail_nxt = rd_b;
          end else begin
            bwd_wr = '{we: 1'b1, addr: rd_f, data: rd_b};
          end
          mark_nxt[s1_tid_r] = 1'b0;
          count_nxt          = count_r - 1'b1;
          if (count_nxt == '0) begin
            head_nxt = '0;
            tail_nxt = '0;
          end
        end
      end
      OP_SCHEDULE: begin
        o_prev = run_thr_r;
        o_pval = run_valid_r;
        push   = run_valid_r && s1_run_r && !mark_r[run_thr_r];
        if (push) begin
          if (count_r != '0) begin
            fwd_wr = '{we: 1'b1, addr: tail_r, data: run_thr_r};
            bwd_wr = '{we: 1'b1, addr: run_thr_r, data: tail_r};
          end else begin
            head_nxt = run_thr_r;
          end
          tail_nxt            = run_thr_r;
          mark_nxt[run_thr_r] = 1'b1;
          count_nxt           = count_r + 1'b1;
        end
        if (count_nxt == '0) begin
          run_valid_nxt = 1'b0;
        end else begin
          pick   = head_nxt;
          o_next = pick;
          o_nval = 1'b1;
          if (count_nxt == COUNT_W'(1)) begin
            head_nxt = '0;
            tail_nxt = '0;
          end else if (push && count_r == COUNT_W'(1)) begin
            head_nxt = run_thr_r;
          end else begin
            head_nxt = rd_f;
          end
          mark_nxt[pick] = 1'b0;
          count_nxt      = count_nxt - 1'b1;
          if (!(run_valid_r && run_thr_r == pick)) begin
            o_sw          = 1'b1;
            run_thr_nxt   = pick;
            run_valid_nxt = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      mark_r      <= '0;
      run_thr_r   <= '0;
      run_valid_r <= 1'b0;
      byp_f_r     <= 1'b0;
      byp_b_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        byp_f_r    <= commit && fwd_wr.we && (fwd_wr.addr == rd_addr);
        byp_b_r    <= commit && bwd_wr.we && (bwd_wr.addr == rd_addr);
      end else if (commit) begin
        s1_valid_r <= 1'b0;
      end
      if (commit) begin
        head_r      <= head_nxt;
        tail_r      <= tail_nxt;
        count_r     <= count_nxt;
        mark_r      <= mark_nxt;
        run_thr_r   <= run_thr_nxt;
        run_valid_r <= run_valid_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r      <= in_operation;
      s1_tid_r     <= in_thread_id;
      s1_run_r     <= in_current_running;
      byp_f_data_r <= fwd_wr.data;
      byp_b_data_r <= bwd_wr.data;
    end
    if (commit) begin
      out_next_r  <= o_next;
      out_nval_r  <= o_nval;
      out_sw_r    <= o_sw;
      out_prev_r  <= o_prev;
      out_pval_r  <= o_pval;
      out_count_r <= count_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_next_thread     = out_next_r;
  assign out_next_valid      = out_nval_r;
  assign out_switch_needed   = out_sw_r;
  assign out_previous_thread = out_prev_r;
  assign out_previous_valid  = out_pval_r;
  assign out_queue_count     = out_count_r;

endmodule

// ===== rtl/rrq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== test/round_robin_ready_queue_unit_test.sv =====
// Self-checking testbench for round_robin_ready_queue_unit: directed and random
// enqueue, removal and schedule requests, each predicted and checked per result.
// Depends on rrq_pkg and the RTL of the unit under test.
module round_robin_ready_queue_unit_test;
  import rrq_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 600;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] tid;
    logic            run;
    bit              drain;
  } request_t;

  typedef struct packed {
    logic [ID_W-1:0]    next_thread;
    logic               next_valid;
    logic               switch_needed;
    logic [ID_W-1:0]    previous_thread;
    logic               previous_valid;
    logic [COUNT_W-1:0] queue_count;
  } pick_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] in_operation = '0;
  logic [ID_W-1:0] in_thread_id = '0;
  logic in_current_running = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ID_W-1:0] out_next_thread;
  logic out_next_valid;
  logic out_switch_needed;
  logic [ID_W-1:0] out_previous_thread;
  logic out_previous_valid;
  logic [COUNT_W-1:0] out_queue_count;

  request_t requests[$];
  pick_t picks_due[$];
  bit drain_next = 1'b0;
  int requests_made = 0;
  int picks_seen = 0;
  int mismatches = 0;

  logic [ID_W-1:0] fwd_link [THREAD_SLOTS] = '{default: '0};
  logic [ID_W-1:0] bwd_link [THREAD_SLOTS] = '{default: '0};
  logic queued [THREAD_SLOTS] = '{default: 1'b0};
  logic [ID_W-1:0] head_id = '0;
  logic [ID_W-1:0] tail_id = '0;
  logic [COUNT_W-1:0] ready_total = '0;
  logic [ID_W-1:0] running_id = '0;
  logic running_ok = 1'b0;

  round_robin_ready_queue_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_thread_id        (in_thread_id),
    .in_current_running  (in_current_running),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_next_thread     (out_next_thread),
    .out_next_valid      (out_next_valid),
    .out_switch_needed   (out_switch_needed),
    .out_previous_thread (out_previous_thread),
    .out_previous_valid  (out_previous_valid),
    .out_queue_count     (out_queue_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void ready_push(logic [ID_W-1:0] id);
    if (int'(id) >= THREAD_SLOTS || queued[id]) return;
    fwd_link[id] = '0;
    if (ready_total != 0) begin
      bwd_link[id] = tail_id;
      fwd_link[tail_id] = id;
    end else begin
      bwd_link[id] = '0;
      head_id = id;
    end
    tail_id = id;
    queued[id] = 1'b1;
    ready_total = ready_total + 1'b1;
  endfunction

  function automatic void ready_unlink(logic [ID_W-1:0] id);
    logic [ID_W-1:0] prv;
    logic [ID_W-1:0] nxt;
    if (int'(id) >= THREAD_SLOTS || !queued[id]) return;
    prv = bwd_link[id];
    nxt = fwd_link[id];
    if (id == head_id) head_id = nxt;
    else fwd_link[prv] = nxt;
    if (id == tail_id) tail_id = prv;
    else bwd_link[nxt] = prv;
    fwd_link[id] = '0;
    bwd_link[id] = '0;
    queued[id] = 1'b0;
    ready_total = ready_total - 1'b1;
    if (ready_total == 0) begin
      head_id = '0;
      tail_id = '0;
    end
  endfunction

  function automatic pick_t apply_request(logic [OP_W-1:0] op, logic [ID_W-1:0] tid,
                                          logic still_running);
    pick_t r;
    logic [ID_W-1:0] h;
    r = '0;
    case (op)
      OP_ENQUEUE: ready_push(tid);
      OP_REMOVE:  ready_unlink(tid);
      OP_SCHEDULE: begin
        r.previous_thread = running_id;
        r.previous_valid  = running_ok;
        if (running_ok && still_running) ready_push(running_id);
        if (ready_total == 0) begin
          running_ok = 1'b0;
        end else begin
          h = head_id;
          ready_unlink(h);
          r.next_thread = h;
          r.next_valid  = 1'b1;
          if (!(r.previous_valid && r.previous_thread == h)) begin
            r.switch_needed = 1'b1;
            running_id = h;
            running_ok = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.queue_count = ready_total;
    return r;
  endfunction

  function automatic void queue_request(logic [OP_W-1:0] op, logic [ID_W-1:0] tid, logic run);
    request_t q;
    q.op = op;
    q.tid = tid;
    q.run = run;
    q.drain = drain_next;
    drain_next = 1'b0;
    requests.push_back(q);
    requests_made++;
  endfunction

  // sender: bursts of transfers separated by random gaps
  always @(posedge clk) begin : drive
    logic busy;
    int burst_left;
    int gap_left;
    request_t q;
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left = 0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) busy = 1'b0;
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (requests.size() != 0 &&
                     !(requests[0].drain && picks_due.size() != 0)) begin
          q = requests.pop_front();
          in_operation       <= q.op;
          in_thread_id       <= q.tid;
          in_current_running <= q.run;
          busy = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_valid <= busy;
    end
  end

  // receiver: random stall pattern from three modes, redrawn periodically, one long hold-off
  always @(posedge clk) begin : receive
    logic rdy;
    int rx_mode;
    int rx_age;
    int hold_left;
    bit hold_done;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_mode = 0;
      rx_age = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      rx_age++;
      if (rx_age >= 48) begin
        rx_age = 0;
        rx_mode = $urandom_range(0, 2);
      end
      case (rx_mode)
        0:       rdy = 1'b1;
        1:       rdy = 1'($urandom_range(0, 1));
        default: rdy = ($urandom_range(0, 3) == 0);
      endcase
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!hold_done && picks_seen >= 150 && in_valid) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        rdy = 1'b0;
      end
      out_ready <= rdy;
    end
  end

  // predict and check on the falling edge before the rising edge at which each transfer lands
  always @(negedge clk) begin : check
    pick_t got;
    pick_t want;
    bit moved;
    int idle;
    if (rst_n) begin
      moved = 1'b0;
      if (in_valid && in_ready) begin
        picks_due.push_back(apply_request(in_operation, in_thread_id, in_current_running));
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        picks_seen++;
        got = '{out_next_thread, out_next_valid, out_switch_needed,
                out_previous_thread, out_previous_valid, out_queue_count};
        if (picks_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transfer: next %0d/%0b switch %0b previous %0d/%0b count %0d",
                     got.next_thread, got.next_valid, got.switch_needed,
                     got.previous_thread, got.previous_valid, got.queue_count);
        end else begin
          want = picks_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("mismatch at result %0d: expected next %0d/%0b switch %0b ", picks_seen,
                     want.next_thread, want.next_valid, want.switch_needed);
              $write("previous %0d/%0b count %0d, ",
                     want.previous_thread, want.previous_valid, want.queue_count);
              $display("got next %0d/%0b switch %0b previous %0d/%0b count %0d",
                       got.next_thread, got.next_valid, got.switch_needed,
                       got.previous_thread, got.previous_valid, got.queue_count);
            end
          end
        end
      end
      idle = moved ? 0 : idle + 1;
      if (idle >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin : stimulus
    int perm [THREAD_SLOTS];
    int len;
    int mode;
    int j;
    int tmp;
    int blk;
    queue_request(OP_SCHEDULE, 6'd0, 1'b1);
    queue_request(OP_SCHEDULE, 6'd63, 1'b0);
    queue_request(OP_ENQUEUE, 6'd0, 1'b0);
    queue_request(OP_ENQUEUE, 6'd63, 1'b1);
    queue_request(OP_ENQUEUE, 6'd0, 1'b0);
    queue_request(OP_REMOVE, 6'd21, 1'b0);
    queue_request(OP_UNUSED, 6'd42, 1'b1);
    queue_request(OP_SCHEDULE, 6'd0, 1'b1);
    queue_request(OP_SCHEDULE, 6'd0, 1'b1);
    queue_request(OP_ENQUEUE, 6'd63, 1'b0);
    queue_request(OP_REMOVE, 6'd63, 1'b0);
    queue_request(OP_REMOVE, 6'd0, 1'b0);
    queue_request(OP_ENQUEUE, 6'd63, 1'b0);
    queue_request(OP_SCHEDULE, 6'd0, 1'b0);
    queue_request(OP_SCHEDULE, 6'd0, 1'b1);
    queue_request(OP_SCHEDULE, 6'd0, 1'b0);
    queue_request(OP_ENQUEUE, 6'd42, 1'b0);
    queue_request(OP_ENQUEUE, 6'd21, 1'b1);
    queue_request(OP_REMOVE, 6'd42, 1'b0);
    queue_request(OP_ENQUEUE, 6'd5, 1'b0);
    queue_request(OP_ENQUEUE, 6'd7, 1'b0);
    queue_request(OP_REMOVE, 6'd5, 1'b1);
    queue_request(OP_REMOVE, 6'd7, 1'b0);
    queue_request(OP_SCHEDULE, 6'd0, 1'b0);
    queue_request(OP_SCHEDULE, 6'd63, 1'b1);

    blk = 0;
    while (requests_made < 25 + RANDOM_ITEMS) begin
      mode = (blk == 0) ? 0 : $urandom_range(0, 3);
      drain_next = (blk == 0) || ($urandom_range(0, 3) == 0);
      case (mode)
        0: begin
          for (int i = 0; i < THREAD_SLOTS; i++) perm[i] = i;
          for (int i = THREAD_SLOTS - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
          end
          len = (blk == 0) ? THREAD_SLOTS : $urandom_range(4, THREAD_SLOTS);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0)
              queue_request(OP_ENQUEUE, ID_W'(perm[$urandom_range(0, i)]), 1'b0);
            queue_request(OP_ENQUEUE, ID_W'(perm[i]), 1'($urandom_range(0, 1)));
          end
        end
        1: begin
          len = $urandom_range(4, 40);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0)
              queue_request($urandom_range(0, 1) ? OP_ENQUEUE : OP_REMOVE,
                            ID_W'($urandom_range(0, THREAD_SLOTS - 1)),
                            1'($urandom_range(0, 1)));
            queue_request(OP_SCHEDULE, ID_W'($urandom_range(0, THREAD_SLOTS - 1)),
                          $urandom_range(0, 3) != 0);
          end
        end
        2: begin
          len = $urandom_range(4, 40);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 7) == 0)
              queue_request(OP_SCHEDULE, ID_W'($urandom_range(0, THREAD_SLOTS - 1)),
                            1'($urandom_range(0, 1)));
            queue_request(OP_REMOVE, ID_W'($urandom_range(0, THREAD_SLOTS - 1)),
                          1'($urandom_range(0, 1)));
          end
        end
        default: begin
          len = $urandom_range(4, 20);
          for (int i = 0; i < len; i++)
            queue_request(OP_W'($urandom_range(0, 3)), ID_W'($urandom_range(0, THREAD_SLOTS - 1)),
                          1'($urandom_range(0, 1)));
        end
      endcase
      blk++;
    end

    while (requests.size() != 0 || in_valid) @(posedge clk);
    while (picks_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rrq_pkg.sv
rtl/rrq_ram.sv
rtl/round_robin_ready_queue_unit.sv
test/round_robin_ready_queue_unit_test.sv
